>>> rtl/core/ssvf_pkg.sv
// ssvf_pkg: control word layout, opcodes and microcode program for the
// substepped state-variable filter sequencer. No dependencies.
`default_nettype none

package ssvf_pkg;

  // field widths fixed by the register map and data formats
  localparam int unsigned CUTOFF_W = 17;
  localparam int unsigned INVQ_W   = 11;
  localparam int unsigned CYC_W    = 8;
  localparam int unsigned SEL_W    = 3;
  localparam int unsigned CFG_W    = 17;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned IN_W     = 22;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned COEF_W   = 19;
  localparam int unsigned PC_W     = 4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_CUTOFF  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INVQ    = 3'd1;
  localparam logic [IDX_W-1:0] REG_CYCLES  = 3'd2;
  localparam logic [IDX_W-1:0] REG_MAXSUB  = 3'd3;
  localparam logic [IDX_W-1:0] REG_OUTSEL  = 3'd4;

  // multiplier operand selection
  localparam logic [2:0] MUL_NONE = 3'd0;
  localparam logic [2:0] MUL_CS   = 3'd1;  // cutoff * step
  localparam logic [2:0] MUL_WH   = 3'd2;  // w * highpass
  localparam logic [2:0] MUL_WB   = 3'd3;  // w * bandpass
  localparam logic [2:0] MUL_BQ   = 3'd4;  // bandpass * inverse q

  // register write-back selection
  localparam logic [2:0] WB_NONE  = 3'd0;
  localparam logic [2:0] WB_STEP  = 3'd1;
  localparam logic [2:0] WB_W     = 3'd2;
  localparam logic [2:0] WB_DBP   = 3'd3;
  localparam logic [2:0] WB_BPLP  = 3'd4;
  localparam logic [2:0] WB_HP    = 3'd5;

  // sequencing
  localparam logic [2:0] SEQ_NEXT     = 3'd0;
  localparam logic [2:0] SEQ_WAIT_IN  = 3'd1;
  localparam logic [2:0] SEQ_JZ       = 3'd2;
  localparam logic [2:0] SEQ_JMP      = 3'd3;
  localparam logic [2:0] SEQ_WAIT_OUT = 3'd4;

  // program addresses
  localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
  localparam logic [PC_W-1:0] PC_CHK  = 4'd1;
  localparam logic [PC_W-1:0] PC_MCS  = 4'd2;
  localparam logic [PC_W-1:0] PC_WBW  = 4'd3;
  localparam logic [PC_W-1:0] PC_MWH  = 4'd4;
  localparam logic [PC_W-1:0] PC_MWB  = 4'd5;
  localparam logic [PC_W-1:0] PC_BPLP = 4'd6;
  localparam logic [PC_W-1:0] PC_MBQ  = 4'd7;
  localparam logic [PC_W-1:0] PC_HP   = 4'd8;
  localparam logic [PC_W-1:0] PC_OUT  = 4'd9;

  typedef struct packed {
    logic [2:0]      mul_sel;
    logic [2:0]      wb_sel;
    logic [2:0]      seq;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  // microcode rom: one substep is PC_MCS through PC_HP
  function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t cw;
    cw = '{MUL_NONE, WB_NONE, SEQ_NEXT, PC_IDLE};
    case (pc)
      PC_IDLE: cw = '{MUL_NONE, WB_NONE, SEQ_WAIT_IN,  PC_CHK};
      PC_CHK:  cw = '{MUL_NONE, WB_STEP, SEQ_JZ,       PC_OUT};
      PC_MCS:  cw = '{MUL_CS,   WB_NONE, SEQ_NEXT,     PC_IDLE};
      PC_WBW:  cw = '{MUL_NONE, WB_W,    SEQ_NEXT,     PC_IDLE};
      PC_MWH:  cw = '{MUL_WH,   WB_NONE, SEQ_NEXT,     PC_IDLE};
      PC_MWB:  cw = '{MUL_WB,   WB_DBP,  SEQ_NEXT,     PC_IDLE};
      PC_BPLP: cw = '{MUL_NONE, WB_BPLP, SEQ_NEXT,     PC_IDLE};
      PC_MBQ:  cw = '{MUL_BQ,   WB_NONE, SEQ_NEXT,     PC_IDLE};
      PC_HP:   cw = '{MUL_NONE, WB_HP,   SEQ_JMP,      PC_CHK};
      PC_OUT:  cw = '{MUL_NONE, WB_NONE, SEQ_WAIT_OUT, PC_IDLE};
      default: cw = '{MUL_NONE, WB_NONE, SEQ_JMP,      PC_IDLE};
    endcase
    return cw;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/ssvf_if.sv
// ssvf_in_if / ssvf_out_if: valid/ready channels for filter input and result beats.
// Depends on ssvf_pkg for payload widths.
`default_nettype none

interface ssvf_in_if
  import ssvf_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic signed [IN_W-1:0]  filter_sum;

  modport source (output valid, output filter_sum, input ready);
  modport sink   (input valid, input filter_sum, output ready);
endinterface

interface ssvf_out_if
  import ssvf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] filter_out;

  modport source (output valid, output filter_out, input ready);
  modport sink   (input valid, input filter_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/substepped_state_variable_filter_core.sv
// substepped_state_variable_filter_core: microcoded two-integrator filter.
// Depends on ssvf_pkg and the channel interfaces in ssvf_if.sv.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    filter_sum  s22
//   out_ch   out  valid/ready    filter_out  s32
//   cfg      in   cfg_we         cfg_index 3b, cfg_data 17b
//
// The number of substeps is the ceiling of cycles per sample over max substep;
// each substep is seven microcode steps sharing one 32x32 multiplier with a
// registered product, plus the loop test.
// Reset is synchronous: program counter to idle, levels to zero, configuration registers to defaults.
// A finished result waits in the output register while the next beat is taken;
// the program only stalls at its output step if that register is full and out_ch.ready is low.
`default_nettype none

module substepped_state_variable_filter_core
  import ssvf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  ssvf_in_if.sink               in_ch,
  ssvf_out_if.source            out_ch
);

  // configuration registers
  logic [CUTOFF_W-1:0] cutoff_r;
  logic [INVQ_W-1:0]   invq_r;
  logic [CYC_W-1:0]    cycles_r;
  logic [CYC_W-1:0]    maxsub_r;
  logic [SEL_W-1:0]    outsel_r;

  // filter state and datapath registers
  logic [DATA_W-1:0] lp_r, bp_r, hp_r;
  logic [DATA_W-1:0] x_r;
  logic [DATA_W-1:0] prod_r, prod_nxt;
  logic [DATA_W-1:0] dbp_r;
  logic [COEF_W-1:0] w_r;
  logic [CYC_W-1:0]  rem_r;
  logic [CYC_W-1:0]  step_r, step_nxt;
  logic [PC_W-1:0]   pc_r, pc_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;

  ctrl_word_t        cw;
  logic [DATA_W-1:0] mul_a, mul_b;
  logic [CYC_W-1:0]  maxsub_eff;
  logic [DATA_W-1:0] sum;
  logic              in_fire, out_load;

  assign cw = ucode_rom(pc_r);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
      invq_r   <= INVQ_W'(1448);
      cycles_r <= '0;
      maxsub_r <= CYC_W'(8);
      outsel_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CUTOFF: cutoff_r <= cfg_data[CUTOFF_W-1:0];
        REG_INVQ:   invq_r   <= cfg_data[INVQ_W-1:0];
        REG_CYCLES: cycles_r <= cfg_data[CYC_W-1:0];
        REG_MAXSUB: maxsub_r <= cfg_data[CYC_W-1:0];
        REG_OUTSEL: outsel_r <= cfg_data[SEL_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier, low 32 bits of the product
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cw.mul_sel)
      MUL_CS: begin
        mul_a = DATA_W'(cutoff_r);
        mul_b = DATA_W'(step_r);
      end
      MUL_WH: begin
        mul_a = DATA_W'(w_r);
        mul_b = hp_r;
      end
      MUL_WB: begin
        mul_a = DATA_W'(w_r);
        mul_b = bp_r;
      end
      MUL_BQ: begin
        mul_a = bp_r;
        mul_b = DATA_W'(invq_r);
      end
      default: ;
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // substep length, clamped to the cycles that remain
  assign maxsub_eff = (maxsub_r == '0) ? CYC_W'(1) : maxsub_r;
  assign step_nxt   = (rem_r < maxsub_eff) ? rem_r : maxsub_eff;

  // selected levels summed for the result
  always_comb begin
    sum = '0;
    if (outsel_r[0]) sum = sum + lp_r;
    if (outsel_r[1]) sum = sum + bp_r;
    if (outsel_r[2]) sum = sum + hp_r;
  end

  // sequencer handshakes
  assign in_ch.ready = (pc_r == PC_IDLE);
  assign in_fire     = (cw.seq == SEQ_WAIT_IN) && in_ch.valid;
  assign out_load    = (cw.seq == SEQ_WAIT_OUT) && (!out_valid_r || out_ch.ready);

  // next step
  always_comb begin
    pc_nxt = pc_r + PC_W'(1);
    case (cw.seq)
      SEQ_NEXT:     pc_nxt = pc_r + PC_W'(1);
      SEQ_WAIT_IN:  pc_nxt = in_fire ? cw.target : pc_r;
      SEQ_JZ:       pc_nxt = (rem_r == '0) ? cw.target : pc_r + PC_W'(1);
      SEQ_JMP:      pc_nxt = cw.target;
      SEQ_WAIT_OUT: pc_nxt = out_load ? cw.target : pc_r;
      default:      pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  // datapath registers without reset
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (in_fire) begin
      x_r   <= DATA_W'($signed(in_ch.filter_sum) >>> 7);
      rem_r <= cycles_r;
    end
    case (cw.wb_sel)
      WB_STEP: step_r <= step_nxt;
      WB_W:    w_r    <= prod_r[COEF_W+5:6];
      WB_DBP:  dbp_r  <= DATA_W'($signed(prod_r) >>> 14);
      WB_HP:   rem_r  <= rem_r - step_r;
      default: ;
    endcase
  end

  // filter levels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_r <= '0;
      bp_r <= '0;
      hp_r <= '0;
    end else begin
      case (cw.wb_sel)
        WB_BPLP: begin
          bp_r <= bp_r - dbp_r;
          lp_r <= lp_r - DATA_W'($signed(prod_r) >>> 14);
        end
        WB_HP:   hp_r <= DATA_W'($signed(prod_r) >>> 10) - lp_r - x_r;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {sum[DATA_W-8:0], 7'b0};
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.filter_out = out_data_r;

endmodule

`default_nettype wire

>>> bench/ssvf_filter_checker.sv
// ssvf_filter_checker: watches the config port and both channels, predicts each
// filter result and compares it with the output beats. Depends on ssvf_pkg, ssvf_if.
`default_nettype none

module ssvf_filter_checker
  import ssvf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  ssvf_in_if                    in_ch,
  ssvf_out_if                   out_ch,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // bit positions of the output select register
  localparam int SEL_LP = 0;
  localparam int SEL_BP = 1;
  localparam int SEL_HP = 2;

  // shadow copy of the register file
  logic [CUTOFF_W-1:0] cutoff_r;
  logic [INVQ_W-1:0]   invq_r;
  logic [CYC_W-1:0]    cycles_r;
  logic [CYC_W-1:0]    maxsub_r;
  logic [SEL_W-1:0]    sel_r;

  // integrator levels, 32-bit wrapping
  int lp_lvl;
  int bp_lvl;
  int hp_lvl;

  logic signed [DATA_W-1:0] filter_out_q[$];

  // runs the substeps for one sample and forms the selected sum
  function automatic logic signed [DATA_W-1:0] filter_sample(
    input logic signed [IN_W-1:0] fs
  );
    int x;
    int w;
    int bp_prev;
    int total;
    int left;
    int span;
    x = int'(fs) >>> 7;
    left = int'(cycles_r);
    span = (maxsub_r == '0) ? 1 : int'(maxsub_r);
    while (left != 0) begin
      // last substep is clamped to what remains
      if (left < span) span = left;
      w = (int'(cutoff_r) * span) >>> 6;
      bp_prev = bp_lvl;
      bp_lvl = bp_lvl - ((w * hp_lvl) >>> 14);
      lp_lvl = lp_lvl - ((w * bp_prev) >>> 14);
      hp_lvl = ((bp_lvl * int'(invq_r)) >>> 10) - lp_lvl - x;
      left = left - span;
    end
    total = 0;
    if (sel_r[SEL_LP]) total = total + lp_lvl;
    if (sel_r[SEL_BP]) total = total + bp_lvl;
    if (sel_r[SEL_HP]) total = total + hp_lvl;
    return DATA_W'(total <<< 7);
  endfunction

  logic signed [DATA_W-1:0] want;

  always @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= '0;
      invq_r   <= INVQ_W'(1448);
      cycles_r <= '0;
      maxsub_r <= CYC_W'(8);
      sel_r    <= '0;
      lp_lvl   = 0;
      bp_lvl   = 0;
      hp_lvl   = 0;
      filter_out_q.delete();
      pending  = 0;
    end else begin
      // register writes; unmapped indexes are ignored
      if (cfg_we) begin
        case (cfg_index)
          REG_CUTOFF: cutoff_r <= cfg_data[CUTOFF_W-1:0];
          REG_INVQ:   invq_r   <= cfg_data[INVQ_W-1:0];
          REG_CYCLES: cycles_r <= cfg_data[CYC_W-1:0];
          REG_MAXSUB: maxsub_r <= cfg_data[CYC_W-1:0];
          REG_OUTSEL: sel_r    <= cfg_data[SEL_W-1:0];
          default: ;
        endcase
      end
      // input beat: predict its result
      if (in_ch.valid && in_ch.ready) filter_out_q.push_back(filter_sample(in_ch.filter_sum));
      // output beat: compare with the oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        if (filter_out_q.size() == 0) begin
          $display("%0t: unexpected result beat, filter_out %0d", $time, out_ch.filter_out);
          fail_count = fail_count + 1;
        end else begin
          want = filter_out_q.pop_front();
          if (out_ch.filter_out !== want) begin
            $display("%0t: filter_out mismatch, expected %0d actual %0d",
                     $time, want, out_ch.filter_out);
            fail_count = fail_count + 1;
          end
        end
      end
      pending = filter_out_q.size();
    end
  end

  initial begin
    fail_count = 0;
    pending = 0;
  end

endmodule

`default_nettype wire

>>> bench/tb_substepped_state_variable_filter_core.sv
// tb_substepped_state_variable_filter_core: clock, reset, register programming and
// sample stimulus for the filter core; depends on ssvf_pkg, ssvf_if and the checker.
`default_nettype none

module tb_substepped_state_variable_filter_core
  import ssvf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // unmapped register index, writes to it must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic signed [IN_W-1:0] IN_MAX = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] IN_MIN = {1'b1, {(IN_W-1){1'b0}}};

  // settle time covers the slowest beat, 255 substeps plus overhead
  localparam int SETTLE_CYCLES = 2100;
  localparam int RANDOM_PHASES = 40;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  bit               steady;
  int               fail_count;
  int               pending;

  ssvf_in_if  in_ch();
  ssvf_out_if out_ch();

  substepped_state_variable_filter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  ssvf_filter_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  // hard stop
  initial begin
    #80ms;
    $display("*** FAILED ***");
    $finish;
  end

  // one register write, taken at the next edge
  task automatic program_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_W'(val);
    @(posedge clk);
  endtask

  task automatic program_all(input int unsigned cut, input int unsigned invq,
                             input int unsigned cyc, input int unsigned maxs,
                             input int unsigned sel);
    program_reg(REG_CUTOFF, cut);
    program_reg(REG_INVQ, invq);
    program_reg(REG_CYCLES, cyc);
    program_reg(REG_MAXSUB, maxs);
    program_reg(REG_OUTSEL, sel);
    cfg_we <= 1'b0;
  endtask

  // send one input beat, with random gaps ahead of it
  task automatic send_sample(input logic signed [IN_W-1:0] v);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.filter_sum <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // drop valid and wait for every predicted result to arrive
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  function automatic logic signed [IN_W-1:0] pick_sample();
    logic signed [IN_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = IN_MAX;
      1:       v = IN_MIN;
      2, 3, 4, 5: v = IN_W'(int'($urandom_range(0, 32767)) - 16384);
      default: v = IN_W'($urandom);
    endcase
    return v;
  endfunction

  // random register setting, each register written most of the time
  task automatic program_random();
    int unsigned val;
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 9))
        0:          val = 0;
        1:          val = 131071;
        2, 3, 4, 5: val = $urandom_range(0, 4095);
        default:    val = $urandom_range(0, 131071);
      endcase
      program_reg(REG_CUTOFF, val);
    end
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 9))
        0:       val = 0;
        1:       val = 2047;
        default: val = $urandom_range(0, 2047);
      endcase
      program_reg(REG_INVQ, val);
    end
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 9))
        0:       val = 0;
        1:       val = 255;
        default: val = $urandom_range(1, 48);
      endcase
      program_reg(REG_CYCLES, val);
    end
    if ($urandom_range(0, 9) < 8) begin
      case ($urandom_range(0, 9))
        0:       val = 0;
        1:       val = 1;
        2:       val = 255;
        default: val = $urandom_range(2, 16);
      endcase
      program_reg(REG_MAXSUB, val);
    end
    if ($urandom_range(0, 9) < 8) program_reg(REG_OUTSEL, $urandom_range(0, 7));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.filter_sum <= '0;
    steady = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: zero cycles and nothing selected
    send_sample(IN_MAX);
    send_sample(IN_MIN);
    drain();

    // full cutoff and q, zero max substep runs single-cycle substeps
    program_all(131071, 2047, 255, 0, 7);
    send_sample(IN_MAX);
    send_sample(IN_MIN);
    send_sample('0);
    send_sample('1);
    drain();

    // zero cycles: output from held levels
    program_reg(REG_CYCLES, 0);
    cfg_we <= 1'b0;
    send_sample(IN_MAX);
    drain();
    program_reg(REG_OUTSEL, 2);
    cfg_we <= 1'b0;
    send_sample(IN_MIN);
    drain();

    // last substep clamped, lowpass then highpass alone, then none selected
    program_all(2000, 1448, 10, 3, 1);
    send_sample(IN_W'(100000));
    send_sample(IN_W'(-100000));
    send_sample(IN_MAX);
    drain();
    program_reg(REG_OUTSEL, 4);
    program_reg(REG_SPARE, 131071);
    cfg_we <= 1'b0;
    send_sample(IN_MIN);
    send_sample(IN_W'(12345));
    drain();
    program_reg(REG_OUTSEL, 0);
    cfg_we <= 1'b0;
    send_sample(IN_MAX);
    drain();

    // one large substep covering everything, zero cutoff and q
    program_all(0, 0, 255, 255, 7);
    send_sample(IN_MAX);
    send_sample(IN_W'(-77));
    drain();

    // random phases, a stretch of them without idling
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      steady = (p >= 10 && p < 15);
      program_random();
      n = $urandom_range(15, 35);
      for (int i = 0; i < n; i++) send_sample(pick_sample());
      drain();
    end
    steady = 1'b0;

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
